// ===== hdl/name_hash_table_double_hashing_defines.svh =====
// Assertion macros shared by the checker of the name hash table.
// Depends on a clock named clk and an active-low reset named arst_n in scope.
`ifndef NAME_HASH_TABLE_DOUBLE_HASHING_DEFINES_SVH
`define NAME_HASH_TABLE_DOUBLE_HASHING_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define NHTDH_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent
`define NHTDH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/nhtdh_pkg.sv =====
// Package of the name hash table: sizes, request and response codes,
// slot states and the command/status structs between controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package nhtdh_pkg;

	// Table and field sizes
	localparam int TABLE_BITS  = 4;
	localparam int TABLE_SIZE  = 1 << TABLE_BITS;
	localparam int NAME_CHARS  = 8;
	localparam int HANDLE_BITS = 16;
	localparam int KEY_BYTES   = 8;
	localparam int KEY_W       = 64;
	localparam int BYTE_IDX_W  = 3;
	localparam int HB_W        = 4;
	localparam int REQ_W       = 2;
	localparam int RSP_W       = 2;
	localparam int HANDLE_W    = 16;
	localparam int SLOT_W      = 10;
	localparam int CNT_W       = TABLE_BITS + 1;

	// Hash and probe step
	localparam int HASH_W      = 32;
	localparam int DIGIT_W     = 4;
	localparam int MOD_DIGITS  = HASH_W / DIGIT_W;
	localparam int MCNT_W      = 3;
	localparam int MOD_D       = TABLE_SIZE - 3;
	localparam int HASH_FOLD   = 24;
	localparam logic [HASH_W-1:0] HASH_TOP = 32'hf000_0000;

	// Insert refuses once count * 4 exceeds three times the slots (over three quarters full)
	localparam int LOAD_LIMIT  = TABLE_SIZE * 3;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_FIND   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

	// Response status codes
	localparam logic [RSP_W-1:0] RSP_OK        = 2'd0;
	localparam logic [RSP_W-1:0] RSP_NOT_FOUND = 2'd1;
	localparam logic [RSP_W-1:0] RSP_FULL      = 2'd2;

	// Slot states
	localparam logic [1:0] SLOT_FREE = 2'd0;
	localparam logic [1:0] SLOT_USED = 2'd1;
	localparam logic [1:0] SLOT_DEL  = 2'd2;

	typedef struct packed {
		logic             clr_wr;
		logic             load;
		logic             hash_step;
		logic             hash_fin;
		logic             mod_step;
		logic             probe_step;
		logic             wr_ins;
		logic             wr_del;
		logic             res_load;
		logic [RSP_W-1:0] res_status;
		logic             res_handle;
		logic             res_slot;
		logic             out_load;
	} nhtdh_cmd_t;

	typedef struct packed {
		logic             clr_last;
		logic [REQ_W-1:0] req_type;
		logic             hash_done;
		logic             mod_last;
		logic             slot_free;
		logic             slot_used;
		logic             hit_lower;
		logic             hit_exact;
		logic             probe_last;
		logic             overload;
	} nhtdh_sts_t;

endpackage

`default_nettype wire

// ===== hdl/nhtdh_req_if.sv =====
// Request channel of the name hash table: valid/ready plus request payload.
// Depends on nhtdh_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface nhtdh_req_if;
	logic                            valid;
	logic                            ready;
	logic [nhtdh_pkg::REQ_W-1:0]     req_type;
	logic [nhtdh_pkg::KEY_W-1:0]     key_name;
	logic [nhtdh_pkg::HANDLE_W-1:0]  entry_handle;

	modport source (output valid, req_type, key_name, entry_handle, input ready);
	modport sink (input valid, req_type, key_name, entry_handle, output ready);
endinterface

`default_nettype wire

// ===== hdl/nhtdh_rsp_if.sv =====
// Response channel of the name hash table: valid/ready plus result payload.
// Depends on nhtdh_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface nhtdh_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [nhtdh_pkg::RSP_W-1:0]     status;
	logic [nhtdh_pkg::HANDLE_W-1:0]  found_handle;
	logic [nhtdh_pkg::SLOT_W-1:0]    slot_index;

	modport source (output valid, status, found_handle, slot_index, input ready);
	modport sink (input valid, status, found_handle, slot_index, output ready);
endinterface

`default_nettype wire

// ===== hdl/name_hash_table_double_hashing.sv =====
// A request is loaded, hashed one character per cycle over its name (0..8 characters),
// reduced to an odd probe step, then probed over 1..16 slots (one slot memory read per cycle);
// type 3 and refused inserts skip the probing. One request at a time: the next is taken
// only after the staged result has moved to the output register, which waits while a
// held response is not yet taken. The step remainder takes one nibble per cycle.
// Reset: async, then a clearing pass over every slot (one slot a cycle) with ready low.
`timescale 1ns / 1ps
`default_nettype none

module name_hash_table_double_hashing (
	input  logic        clk,
	input  logic        arst_n,
	nhtdh_req_if.sink   req,
	nhtdh_rsp_if.source rsp
);

	nhtdh_pkg::nhtdh_cmd_t cmd;
	nhtdh_pkg::nhtdh_sts_t sts;

	// Sequencing and handshakes
	nhtdh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Hashing, slot storage and results
	nhtdh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req.req_type),
		.key_name     (req.key_name),
		.entry_handle (req.entry_handle),
		.status       (rsp.status),
		.found_handle (rsp.found_handle),
		.slot_index   (rsp.slot_index)
	);

endmodule

`default_nettype wire

// ===== hdl/nhtdh_ctrl.sv =====
// Controller of the name hash table: sequences clearing, hashing, step
// reduction and probing, and drives the handshakes. Depends on nhtdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nhtdh_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  nhtdh_pkg::nhtdh_sts_t sts,
	output nhtdh_pkg::nhtdh_cmd_t cmd
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_HASH  = 3'd2;
	localparam logic [2:0] ST_MOD   = 3'd3;
	localparam logic [2:0] ST_ISSUE = 3'd4;
	localparam logic [2:0] ST_PROBE = 3'd5;
	localparam logic [2:0] ST_POST  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_HASH;
				end
			end
			ST_HASH: begin
				if (sts.hash_done) begin
					cmd.hash_fin = 1'b1;
					state_nxt    = ST_MOD;
				end else begin
					cmd.hash_step = 1'b1;
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					if (sts.req_type == nhtdh_pkg::REQ_INSERT && sts.overload) begin
						cmd.res_load   = 1'b1;
						cmd.res_status = nhtdh_pkg::RSP_FULL;
						state_nxt      = ST_POST;
					end else if (sts.req_type inside {nhtdh_pkg::REQ_FIND,
							nhtdh_pkg::REQ_INSERT, nhtdh_pkg::REQ_DELETE}) begin
						state_nxt = ST_ISSUE;
					end else begin
						cmd.res_load   = 1'b1;
						cmd.res_status = nhtdh_pkg::RSP_NOT_FOUND;
						state_nxt      = ST_POST;
					end
				end
			end
			ST_ISSUE: begin
				cmd.probe_step = 1'b1;
				state_nxt      = ST_PROBE;
			end
			ST_PROBE: begin
				cmd.probe_step = 1'b1;
				case (sts.req_type)
					nhtdh_pkg::REQ_FIND: begin
						if (sts.slot_free) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = nhtdh_pkg::RSP_NOT_FOUND;
						end else if (sts.slot_used && sts.hit_lower) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = nhtdh_pkg::RSP_OK;
							cmd.res_handle = 1'b1;
							cmd.res_slot   = 1'b1;
						end else if (sts.probe_last) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = nhtdh_pkg::RSP_NOT_FOUND;
						end
					end
					nhtdh_pkg::REQ_DELETE: begin
						if (sts.slot_free) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = nhtdh_pkg::RSP_NOT_FOUND;
						end else if (sts.slot_used && sts.hit_exact) begin
							cmd.wr_del     = 1'b1;
							cmd.res_load   = 1'b1;
							cmd.res_status = nhtdh_pkg::RSP_OK;
							cmd.res_slot   = 1'b1;
						end else if (sts.probe_last) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = nhtdh_pkg::RSP_NOT_FOUND;
						end
					end
					nhtdh_pkg::REQ_INSERT: begin
						if (!sts.slot_used) begin
							cmd.wr_ins     = 1'b1;
							cmd.res_load   = 1'b1;
							cmd.res_status = nhtdh_pkg::RSP_OK;
							cmd.res_slot   = 1'b1;
						end else if (sts.probe_last) begin
							cmd.res_load   = 1'b1;
							cmd.res_status = nhtdh_pkg::RSP_FULL;
						end
					end
					default: begin
						cmd.res_load   = 1'b1;
						cmd.res_status = nhtdh_pkg::RSP_NOT_FOUND;
					end
				endcase
				if (cmd.res_load) begin
					state_nxt = ST_POST;
				end
			end
			ST_POST: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Hold the response valid until the response is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/nhtdh_dp.sv =====
// Datapath of the name hash table: key canonicalization, ELF hash, step
// reduction, slot memories, probe read pipeline, entry count and result
// registers. Depends on nhtdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nhtdh_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  nhtdh_pkg::nhtdh_cmd_t                cmd,
	output nhtdh_pkg::nhtdh_sts_t                sts,
	input  logic [nhtdh_pkg::REQ_W-1:0]          req_type,
	input  logic [nhtdh_pkg::KEY_W-1:0]          key_name,
	input  logic [nhtdh_pkg::HANDLE_W-1:0]       entry_handle,
	output logic [nhtdh_pkg::RSP_W-1:0]          status,
	output logic [nhtdh_pkg::HANDLE_W-1:0]       found_handle,
	output logic [nhtdh_pkg::SLOT_W-1:0]         slot_index
);

	localparam int TB  = nhtdh_pkg::TABLE_BITS;
	localparam int VW  = TB + nhtdh_pkg::DIGIT_W;
	localparam int KW  = nhtdh_pkg::KEY_W;
	localparam int HW  = nhtdh_pkg::HASH_W;
	localparam int HBW = nhtdh_pkg::HANDLE_BITS;

	// Lower-case A..Z in every byte
	function automatic logic [KW-1:0] lower_key(input logic [KW-1:0] k);
		logic [KW-1:0] r;
		logic [7:0]    b;
		r = '0;
		for (int i = 0; i < nhtdh_pkg::KEY_BYTES; i++) begin
			b = k[8*i +: 8];
			if (b inside {[8'h41:8'h5a]}) begin
				b = b + 8'h20;
			end
			r[8*i +: 8] = b;
		end
		return r;
	endfunction

	// Reduce one partial remainder digit step modulo the step divisor
	function automatic logic [TB-1:0] mod_reduce(input logic [VW-1:0] v);
		logic [VW-1:0] rem;
		rem = v;
		for (int k = 1; k < (1 << nhtdh_pkg::DIGIT_W); k++) begin
			if (v >= VW'(k * nhtdh_pkg::MOD_D)) begin
				rem = v - VW'(k * nhtdh_pkg::MOD_D);
			end
		end
		return rem[TB-1:0];
	endfunction

	// Slot memories
	logic [KW-1:0]  key_mem [nhtdh_pkg::TABLE_SIZE];
	logic [HBW-1:0] val_mem [nhtdh_pkg::TABLE_SIZE];
	logic [1:0]     stat_mem [nhtdh_pkg::TABLE_SIZE];

	// Request registers
	logic [nhtdh_pkg::REQ_W-1:0] req_q;
	logic [KW-1:0]               key_q;
	logic [HBW-1:0]              hnd_q;

	// Hash and step registers
	logic [nhtdh_pkg::HB_W-1:0]   hb_q;
	logic [HW-1:0]                h_q;
	logic [HW-1:0]                x_q;
	logic [TB-1:0]                r_q;
	logic [nhtdh_pkg::MCNT_W-1:0] mcnt_q;

	// Probe pipeline
	logic [TB-1:0]  pidx_q;
	logic [TB-1:0]  pn_q;
	logic [TB-1:0]  idx_s1;
	logic [TB-1:0]  pn_s1;
	logic [1:0]     stat_s1;
	logic [KW-1:0]  key_s1;
	logic [HBW-1:0] val_s1;

	// Count, clearing and results
	logic [nhtdh_pkg::CNT_W-1:0]    cnt_q;
	logic [TB-1:0]                  clr_q;
	logic [nhtdh_pkg::RSP_W-1:0]    res_status_q;
	logic [nhtdh_pkg::HANDLE_W-1:0] res_handle_q;
	logic [nhtdh_pkg::SLOT_W-1:0]   res_slot_q;
	logic [nhtdh_pkg::RSP_W-1:0]    out_status_q;
	logic [nhtdh_pkg::HANDLE_W-1:0] out_handle_q;
	logic [nhtdh_pkg::SLOT_W-1:0]   out_slot_q;

	logic [KW-1:0] canon;
	logic [KW-1:0] lkey;
	logic [7:0]    hchar;
	logic [HW-1:0] hsum;
	logic [HW-1:0] htop;
	logic [HW-1:0] hnext;
	logic [TB-1:0] step;
	logic [VW-1:0] mod_in;

	// Keep name bytes up to the first zero byte or the name length
	always_comb begin
		logic       live;
		logic [7:0] b;
		live  = 1'b1;
		canon = '0;
		for (int k = 0; k < nhtdh_pkg::KEY_BYTES; k++) begin
			b = key_name[8*k +: 8];
			if (k >= nhtdh_pkg::NAME_CHARS || b == 8'h00) begin
				live = 1'b0;
			end
			canon[8*k +: 8] = live ? b : 8'h00;
		end
	end

	assign lkey = lower_key(key_q);

	// One ELF hash character step
	always_comb begin
		hchar = lkey[8*hb_q[nhtdh_pkg::BYTE_IDX_W-1:0] +: 8];
		hsum  = {h_q[HW-5:0], 4'b0000} + HW'(hchar);
		htop  = hsum & nhtdh_pkg::HASH_TOP;
		hnext = (htop != '0) ? (hsum ^ (htop >> nhtdh_pkg::HASH_FOLD) ^ htop) : hsum;
	end

	assign mod_in = {r_q, x_q[HW-1 -: nhtdh_pkg::DIGIT_W]};
	assign step   = r_q | TB'(1);

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
			key_q <= canon;
			hnd_q <= entry_handle[HBW-1:0];
		end
	end

	// Hash, then reduce the step digit by digit
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hb_q <= '0;
			h_q  <= '0;
		end else if (cmd.hash_step) begin
			hb_q <= hb_q + nhtdh_pkg::HB_W'(1);
			h_q  <= hnext;
		end
		if (cmd.hash_fin) begin
			x_q    <= HW'(nhtdh_pkg::MOD_D) - h_q;
			r_q    <= '0;
			mcnt_q <= '0;
		end else if (cmd.mod_step) begin
			x_q    <= x_q << nhtdh_pkg::DIGIT_W;
			r_q    <= mod_reduce(mod_in);
			mcnt_q <= mcnt_q + nhtdh_pkg::MCNT_W'(1);
		end
	end

	// Advance the probe address and read all slot memories
	always_ff @(posedge clk) begin
		if (cmd.hash_fin) begin
			pidx_q <= h_q[TB-1:0];
			pn_q   <= '0;
		end else if (cmd.probe_step) begin
			pidx_q  <= pidx_q + step;
			pn_q    <= pn_q + TB'(1);
			idx_s1  <= pidx_q;
			pn_s1   <= pn_q;
			stat_s1 <= stat_mem[pidx_q];
			key_s1  <= key_mem[pidx_q];
			val_s1  <= val_mem[pidx_q];
		end
	end

	// Write slot state: clearing pass, insert or delete
	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			stat_mem[clr_q] <= nhtdh_pkg::SLOT_FREE;
		end else if (cmd.wr_ins) begin
			stat_mem[idx_s1] <= nhtdh_pkg::SLOT_USED;
		end else if (cmd.wr_del) begin
			stat_mem[idx_s1] <= nhtdh_pkg::SLOT_DEL;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_ins) begin
			key_mem[idx_s1] <= key_q;
			val_mem[idx_s1] <= hnd_q;
		end
	end

	// Clearing counter and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + TB'(1);
			end
			if (cmd.wr_ins) begin
				cnt_q <= cnt_q + nhtdh_pkg::CNT_W'(1);
			end else if (cmd.wr_del) begin
				cnt_q <= cnt_q - nhtdh_pkg::CNT_W'(1);
			end
		end
	end

	// Stage the result, then move it to the output register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_handle_q <= cmd.res_handle ? nhtdh_pkg::HANDLE_W'(val_s1) : '0;
			res_slot_q   <= cmd.res_slot ? nhtdh_pkg::SLOT_W'(idx_s1) : '0;
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_handle_q <= res_handle_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign status       = out_status_q;
	assign found_handle = out_handle_q;
	assign slot_index   = out_slot_q;

	// Status toward the controller
	always_comb begin
		sts            = '0;
		sts.clr_last   = (clr_q == '1);
		sts.req_type   = req_q;
		sts.hash_done  = (hchar == 8'h00) ||
			(hb_q == nhtdh_pkg::HB_W'(nhtdh_pkg::KEY_BYTES));
		sts.mod_last   = (mcnt_q == nhtdh_pkg::MCNT_W'(nhtdh_pkg::MOD_DIGITS - 1));
		sts.slot_free  = (stat_s1 == nhtdh_pkg::SLOT_FREE);
		sts.slot_used  = (stat_s1 == nhtdh_pkg::SLOT_USED);
		sts.hit_lower  = (lower_key(key_s1) == lkey);
		sts.hit_exact  = (key_s1 == key_q);
		sts.probe_last = (pn_s1 == '1);
		sts.overload   = ({cnt_q, 2'b00} >
			(nhtdh_pkg::CNT_W + 2)'(nhtdh_pkg::LOAD_LIMIT));
	end

endmodule

`default_nettype wire

// ===== hdl/nhtdh_chk.sv =====
// Port checker of the name hash table and its bind to the top level.
// Depends on nhtdh_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none
`include "name_hash_table_double_hashing_defines.svh"

module nhtdh_chk (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [nhtdh_pkg::RSP_W-1:0]     rsp_status,
	input logic [nhtdh_pkg::HANDLE_W-1:0]  rsp_found_handle,
	input logic [nhtdh_pkg::SLOT_W-1:0]    rsp_slot_index
);

	// Hold a stalled response
	`NHTDH_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
	`NHTDH_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_status) && $stable(rsp_found_handle) && $stable(rsp_slot_index), "response changed while stalled")

	// Failed requests carry no slot and no handle
	`NHTDH_ASSERT_SAME(a_fail_zero, rsp_valid && rsp_status != nhtdh_pkg::RSP_OK, rsp_slot_index == '0 && rsp_found_handle == '0, "failed response with slot or handle")

	// Known status and a slot inside the table
	`NHTDH_ASSERT_SAME(a_rsp_range, rsp_valid, (rsp_status == nhtdh_pkg::RSP_OK || rsp_status == nhtdh_pkg::RSP_NOT_FOUND || rsp_status == nhtdh_pkg::RSP_FULL) && rsp_slot_index < nhtdh_pkg::SLOT_W'(nhtdh_pkg::TABLE_SIZE), "response out of range")

endmodule

bind name_hash_table_double_hashing nhtdh_chk u_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_found_handle (rsp.found_handle),
	.rsp_slot_index   (rsp.slot_index)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the name hash table: directed and random find, insert, delete and
// unused-code requests, each checked against a predicting scoreboard. Depends on nhtdh_pkg, the two
// channel interfaces and the name_hash_table_double_hashing top level.
`timescale 1ns / 1ps

module testbench;
	import nhtdh_pkg::*;

	// Request code the block leaves unused
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_ITEMS = 1520;
	localparam int CALM_ITEMS   = 150;
	localparam int POOL_SIZE    = 20;

	typedef struct packed {
		logic [RSP_W-1:0]    status;
		logic [HANDLE_W-1:0] handle;
		logic [SLOT_W-1:0]   slot;
	} table_reply_t;

	// Mirror of the slot table; predicts one reply per request
	class name_table_scoreboard;
		logic [KEY_W-1:0]    stored_name[TABLE_SIZE];
		logic [HANDLE_W-1:0] stored_handle[TABLE_SIZE];
		logic [1:0]          slot_state[TABLE_SIZE];
		int unsigned         live_entries;
		table_reply_t        pending_replies[$];
		int unsigned         fail_count;

		function new();
			for (int s = 0; s < TABLE_SIZE; s++) begin
				stored_name[s] = '0;
				stored_handle[s] = '0;
				slot_state[s] = SLOT_FREE;
			end
			live_entries = 0;
			fail_count = 0;
		endfunction

		// Keep bytes up to the first zero, clear the rest
		function logic [KEY_W-1:0] trim_name(logic [KEY_W-1:0] raw);
			logic [KEY_W-1:0] r;
			bit ended;
			r = '0;
			ended = 0;
			for (int i = 0; i < NAME_CHARS; i++) begin
				if (raw[8*i +: 8] == 8'h00)
					ended = 1;
				if (!ended)
					r[8*i +: 8] = raw[8*i +: 8];
			end
			return r;
		endfunction

		function logic [KEY_W-1:0] fold_case(logic [KEY_W-1:0] name);
			logic [KEY_W-1:0] r;
			logic [7:0] b;
			for (int i = 0; i < KEY_BYTES; i++) begin
				b = name[8*i +: 8];
				if (b >= 8'h41 && b <= 8'h5a)
					b = b + 8'h20;
				r[8*i +: 8] = b;
			end
			return r;
		endfunction

		// Shift/fold hash over the lower-case name, then home slot and odd probe step
		function void hash_name(input logic [KEY_W-1:0] lname,
				output logic [TABLE_BITS-1:0] home, output logic [TABLE_BITS-1:0] stride);
			logic [HASH_W-1:0] h, g, d, u;
			bit ended;
			h = '0;
			ended = 0;
			for (int i = 0; i < KEY_BYTES; i++) begin
				if (lname[8*i +: 8] == 8'h00)
					ended = 1;
				if (!ended) begin
					h = (h << 4) + HASH_W'(lname[8*i +: 8]);
					g = h & HASH_TOP;
					if (g != '0) begin
						h ^= g >> HASH_FOLD;
						h ^= g;
					end
				end
			end
			d = HASH_W'(MOD_D);
			u = (d - h) % d;
			u |= 1;
			home = h[TABLE_BITS-1:0];
			stride = u[TABLE_BITS-1:0];
		endfunction

		// Apply one accepted request to the mirror and queue its reply
		function void note_request(logic [REQ_W-1:0] kind, logic [KEY_W-1:0] raw,
				logic [HANDLE_W-1:0] handle);
			logic [KEY_W-1:0] name, lname;
			logic [TABLE_BITS-1:0] pos, stride;
			table_reply_t reply;
			bit hit;
			name = trim_name(raw);
			lname = fold_case(name);
			hash_name(lname, pos, stride);
			reply.status = RSP_NOT_FOUND;
			reply.handle = '0;
			reply.slot = '0;
			case (kind)
				REQ_FIND, REQ_DELETE: begin
					for (int n = 0; n < TABLE_SIZE; n++) begin
						if (slot_state[pos] == SLOT_FREE)
							break;
						if (slot_state[pos] == SLOT_USED) begin
							hit = (kind == REQ_FIND) ? (fold_case(stored_name[pos]) == lname)
								: (stored_name[pos] == name);
							if (hit) begin
								reply.status = RSP_OK;
								reply.slot = SLOT_W'(pos);
								if (kind == REQ_FIND) begin
									reply.handle = stored_handle[pos];
								end else begin
									slot_state[pos] = SLOT_DEL;
									live_entries--;
								end
								break;
							end
						end
						pos = pos + stride;
					end
				end
				REQ_INSERT: begin
					reply.status = RSP_FULL;
					if (live_entries * 4 <= LOAD_LIMIT) begin
						for (int n = 0; n < TABLE_SIZE; n++) begin
							if (slot_state[pos] != SLOT_USED) begin
								slot_state[pos] = SLOT_USED;
								stored_name[pos] = name;
								stored_handle[pos] = handle;
								live_entries++;
								reply.status = RSP_OK;
								reply.slot = SLOT_W'(pos);
								break;
							end
							pos = pos + stride;
						end
					end
				end
				default: ;
			endcase
			pending_replies.push_back(reply);
		endfunction

		task report_mismatch(string what, logic [KEY_W-1:0] got, logic [KEY_W-1:0] want);
			$display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, want);
			fail_count++;
		endtask

		// Compare one delivered reply with the oldest prediction
		task check_reply(table_reply_t got);
			table_reply_t want;
			if (pending_replies.size() == 0) begin
				report_mismatch("unexpected reply", KEY_W'(got), '0);
			end else begin
				want = pending_replies.pop_front();
				if (got.status !== want.status)
					report_mismatch("status", KEY_W'(got.status), KEY_W'(want.status));
				if (got.handle !== want.handle)
					report_mismatch("found_handle", KEY_W'(got.handle), KEY_W'(want.handle));
				if (got.slot !== want.slot)
					report_mismatch("slot_index", KEY_W'(got.slot), KEY_W'(want.slot));
			end
		endtask

		function int pending();
			return pending_replies.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit quiet;
	int unsigned cycle_count;
	logic [KEY_W-1:0] name_pool[POOL_SIZE];
	name_table_scoreboard sb;

	nhtdh_req_if req_ch();
	nhtdh_rsp_if rsp_ch();

	name_hash_table_double_hashing u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Check every reply taken by the bench
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_reply('{rsp_ch.status, rsp_ch.found_handle, rsp_ch.slot_index});
	end

	// Drop ready in random bursts, except in the calm tail
	initial begin
		int unsigned hold_cycles;
		hold_cycles = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				hold_cycles--;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				hold_cycles = $urandom_range(1, 15) - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	function automatic logic [KEY_W-1:0] random_name();
		logic [KEY_W-1:0] r;
		int len;
		r = '0;
		len = $urandom_range(0, 8);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) < 7)
				r[8*i +: 8] = ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
			else
				r[8*i +: 8] = 8'($urandom_range(1, 255));
		end
		return r;
	endfunction

	// Flip letter case at random and fill the bytes past the terminator
	function automatic logic [KEY_W-1:0] disguise_name(logic [KEY_W-1:0] name, bit keep_case);
		logic [KEY_W-1:0] r;
		logic [7:0] b;
		bit ended;
		r = name;
		ended = 0;
		for (int i = 0; i < KEY_BYTES; i++) begin
			b = r[8*i +: 8];
			if (ended) begin
				r[8*i +: 8] = 8'($urandom_range(0, 255));
			end else if (b == 8'h00) begin
				ended = 1;
			end else if (!keep_case && ((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a))) begin
				if ($urandom_range(0, 1))
					r[8*i +: 8] = b ^ 8'h20;
			end
		end
		return r;
	endfunction

	// Present one request, hold it until taken, then note it
	task automatic send_request(logic [REQ_W-1:0] kind, logic [KEY_W-1:0] name,
			logic [HANDLE_W-1:0] handle);
		int unsigned gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= kind;
		req_ch.key_name <= name;
		req_ch.entry_handle <= handle;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(kind, name, handle);
		@(negedge clk);
	endtask

	initial begin
		int pick, roll;
		logic [KEY_W-1:0] name;
		arst_n = 1'b0;
		cycle_count = 0;
		quiet = 0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_FIND;
		req_ch.key_name = '0;
		req_ch.entry_handle = '0;
		sb = new();
		name_pool[0] = '0;
		name_pool[1] = 64'hffff_ffff_ffff_ffff;
		for (int i = 2; i < POOL_SIZE; i++)
			name_pool[i] = random_name();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Empty table, unused code
		send_request(REQ_FIND, 64'h0, 16'h0);
		send_request(REQ_DELETE, 64'h6f6c6c6548, 16'h0);
		send_request(REQ_UNUSED, 64'hffff_ffff_ffff_ffff, 16'hffff);
		// Case-insensitive find, exact delete
		send_request(REQ_INSERT, 64'h6168706c41, 16'h0000);
		send_request(REQ_FIND, 64'h4148504c41, 16'h0);
		send_request(REQ_DELETE, 64'h6168706c61, 16'h0);
		// Empty name, bytes past the terminator ignored
		send_request(REQ_INSERT, 64'h0, 16'hffff);
		send_request(REQ_FIND, 64'h1234_5678_9abc_de00, 16'h0);
		// Full-length name of top byte values
		send_request(REQ_INSERT, 64'hffff_ffff_ffff_ffff, 16'ha5a5);
		send_request(REQ_FIND, 64'hffff_ffff_ffff_ffff, 16'h0);
		// Duplicate insert keeps two copies
		send_request(REQ_INSERT, 64'h6168706c41, 16'h0001);
		send_request(REQ_FIND, 64'h6168706c61, 16'h0);
		send_request(REQ_DELETE, 64'h6168706c41, 16'h0);
		send_request(REQ_FIND, 64'h6168706c61, 16'h0);
		// Bytes just outside the upper-case range stay as they are
		send_request(REQ_INSERT, 64'h5a7b605b40, 16'h5a5a);
		send_request(REQ_FIND, 64'h7a7b605b40, 16'h0);
		send_request(REQ_FIND, 64'h5a7b605b40, 16'h0);
		// Fill past the load limit
		for (int i = 0; i < 10; i++)
			send_request(REQ_INSERT, random_name(), 16'($urandom_range(0, 65535)));

		// Mostly pool names with random case and tails, some noise
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_ITEMS)
				quiet = 1;
			pick = $urandom_range(0, POOL_SIZE - 1);
			if ($urandom_range(0, 19) == 0)
				name_pool[pick] = random_name();
			name = name_pool[pick];
			roll = $urandom_range(0, 99);
			if (roll < 4)
				send_request(REQ_UNUSED, {$urandom, $urandom}, 16'($urandom_range(0, 65535)));
			else if (roll < 8)
				send_request(2'($urandom_range(0, 2)), {$urandom, $urandom},
					16'($urandom_range(0, 65535)));
			else if (roll < 43)
				send_request(REQ_INSERT, disguise_name(name, 1'($urandom_range(0, 1))),
					16'($urandom_range(0, 65535)));
			else if (roll < 70)
				send_request(REQ_FIND, disguise_name(name, 1'b0), 16'($urandom_range(0, 65535)));
			else
				send_request(REQ_DELETE, disguise_name(name, $urandom_range(0, 9) < 7),
					16'($urandom_range(0, 65535)));
		end
		req_ch.valid <= 1'b0;

		// Drain outstanding replies
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
